### rtl/anzcv_pkg.sv
// ---------------------------------------------------------------------------
// anzcv_pkg : shared types and constants for the NZCV ALU
// Action codes, flag bit positions and the multiply/divide unit interface.
// ---------------------------------------------------------------------------
package anzcv_pkg;

   typedef enum logic [4:0] {
      ACT_MOV  = 5'd0,
      ACT_ADD  = 5'd1,
      ACT_SUB  = 5'd2,
      ACT_MUL  = 5'd3,
      ACT_DIV  = 5'd4,
      ACT_CMP  = 5'd5,
      ACT_AND  = 5'd6,
      ACT_OR   = 5'd7,
      ACT_XOR  = 5'd8,
      ACT_SWAP = 5'd9,
      ACT_SHL  = 5'd10,
      ACT_SHR  = 5'd11,
      ACT_SAR  = 5'd12,
      ACT_LDL  = 5'd13,
      ACT_LDH  = 5'd14,
      ACT_NOT  = 5'd15,
      ACT_JMP  = 5'd16,
      ACT_JP   = 5'd17,
      ACT_JN   = 5'd18,
      ACT_JZ   = 5'd19,
      ACT_JC   = 5'd20,
      ACT_JV   = 5'd21,
      ACT_JNP  = 5'd22,
      ACT_JNN  = 5'd23,
      ACT_JNZ  = 5'd24,
      ACT_STOP = 5'd25
   } action_type;

   localparam int unsigned FLAG_N = 3;
   localparam int unsigned FLAG_Z = 2;
   localparam int unsigned FLAG_C = 1;
   localparam int unsigned FLAG_V = 0;

   localparam logic [15:0] HALF_MASK = 16'hFFFF;

   // control into the multiply/divide unit
   typedef struct packed {
      logic start;
      logic is_div;
   } md_ctl_type;

   // status out of the multiply/divide unit
   typedef struct packed {
      logic        done;
      logic [31:0] low;    // product low word or quotient
      logic [31:0] high;   // product high word or remainder
      logic        carry;  // unsigned product overflow
      logic        ovf;    // signed product overflow
   } md_sts_type;

   function automatic logic [3:0] nz_flags(input logic [31:0] r, input logic c,
                                           input logic v);
      logic [3:0] f;
      f         = '0;
      f[FLAG_N] = r[31];
      f[FLAG_Z] = (r == '0);
      f[FLAG_C] = c;
      f[FLAG_V] = v;
      return f;
   endfunction

endpackage

### rtl/alu_with_nzcv_flags_and_branch.sv
// ---------------------------------------------------------------------------
// alu_with_nzcv_flags_and_branch : 32-bit ALU with NZCV flags and branches
// Executes one instruction per transfer, keeps the condition flags and
// resolves jumps against the code segment base.
// ---------------------------------------------------------------------------
//  channel | ports                 | direction | transfer when
//  --------+-----------------------+-----------+--------------------------
//  req     | action, operand_a/b   | in        | req_valid & !req_stall
//  rsp     | results, flags, jump  | out       | rsp_valid & !rsp_stall
//  csr     | write_enable/data     | in        | csr_write_enable
//
//  Quick operations are registered straight into the result register. mul
//  and div by a nonzero divisor pass through the shared multiply/divide
//  unit (32 bit steps, a fix-up and the result register), during which
//  req_stall is held.
//  A new request is taken while the result register is empty or drains.
//  Synchronous reset clears flags, base and the valid state.
// ---------------------------------------------------------------------------
module alu_with_nzcv_flags_and_branch (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [4:0]         req_action,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_first,
   output logic               rsp_write_first,
   output logic signed [31:0] rsp_result_second,
   output logic               rsp_write_second,
   output logic signed [31:0] rsp_remainder,
   output logic               rsp_write_remainder,
   output logic [3:0]         rsp_flags_out,
   output logic               rsp_jump_taken,
   output logic [31:0]        rsp_jump_target,
   output logic               rsp_stop_request,
   output logic               rsp_divide_by_zero,
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data
);
   import anzcv_pkg::*;

   typedef enum logic {ST_READY, ST_BUSY} state_type;

   state_type   state_ff;
   logic [3:0]  flags_ff;
   logic [31:0] base_ff;
   logic        div_ff, div_ovf_ff;
   logic        rsp_valid_ff;
   logic [31:0] r1_ff, r2_ff, rem_ff, tgt_ff;
   logic        w1_ff, w2_ff, wr_ff, jt_ff, stop_ff, dz_ff;
   logic [3:0]  fo_ff;

   md_ctl_type  md_ctl;
   md_sts_type  md_sts;

   logic        accept, use_md;
   logic [31:0] a, b;
   logic [31:0] q_r1, q_r2, q_tgt;
   logic        q_w1, q_w2, q_jt, q_stop, q_dz;
   logic [3:0]  q_f;
   logic [32:0] q_sum;
   logic [63:0] shl_wide;
   logic [31:0] shr_mask, sh_r;
   logic        sh_neg, sh_big;
   logic [4:0]  sh_k;
   logic        sh_c, sh_v;

   assign a = req_operand_a;
   assign b = req_operand_b;

   assign req_stall = (state_ff == ST_BUSY) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign use_md    = (req_action == ACT_MUL) || ((req_action == ACT_DIV) && (b != '0));

   assign md_ctl.start  = accept && use_md;
   assign md_ctl.is_div = (req_action == ACT_DIV);

   anzcv_muldiv u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .ctl       (md_ctl),
      .operand_a (a),
      .operand_b (b),
      .sts       (md_sts)
   );

   // quick operations (all but mul and div by a nonzero divisor)
   always_comb begin
      q_r1 = '0; q_r2 = '0; q_tgt = '0;
      q_w1 = 1'b0; q_w2 = 1'b0; q_jt = 1'b0; q_stop = 1'b0; q_dz = 1'b0;
      q_f  = flags_ff;
      q_sum = '0;

      // shift count classes: negative, 32 or more, 1..31
      sh_neg   = b[31];
      sh_big   = !b[31] && (b[30:5] != '0);
      sh_k     = b[4:0];
      shl_wide = {32'd0, a} << sh_k;
      shr_mask = ~(32'hFFFF_FFFF << sh_k);
      sh_r = a; sh_c = 1'b0; sh_v = 1'b0;
      if (sh_big) begin
         sh_c = (a != '0);
         sh_v = (req_action == ACT_SHL) && (a != '0);
         sh_r = ((req_action == ACT_SAR) && a[31]) ? 32'hFFFF_FFFF : 32'd0;
      end else if (!sh_neg && (sh_k != '0)) begin
         if (req_action == ACT_SHL) begin
            sh_r = shl_wide[31:0];
            sh_c = (shl_wide[63:32] != '0);
            // overflow when shifting back does not restore the operand
            sh_v = (($signed(shl_wide[31:0]) >>> sh_k) != $signed(a));
         end else begin
            sh_c = ((a & shr_mask) != '0);
            sh_r = (req_action == ACT_SAR) ? 32'($signed(a) >>> sh_k) : (a >> sh_k);
         end
      end

      unique case (req_action)
         ACT_MOV: begin q_r1 = b; q_w1 = 1'b1; q_f = nz_flags(b, 1'b0, 1'b0); end
         ACT_ADD: begin
            q_sum = {1'b0, a} + {1'b0, b};
            q_r1 = q_sum[31:0]; q_w1 = 1'b1;
            q_f = nz_flags(q_sum[31:0], q_sum[32],
                           (a[31] == b[31]) && (q_sum[31] != a[31]));
         end
         ACT_SUB, ACT_CMP: begin
            q_sum = {1'b0, a} - {1'b0, b};
            q_r1 = (req_action == ACT_SUB) ? q_sum[31:0] : 32'd0;
            q_w1 = (req_action == ACT_SUB);
            // C on a signed a < b
            q_f = nz_flags(q_sum[31:0], (a[31] != b[31]) ? a[31] : q_sum[32],
                           (a[31] != b[31]) && (q_sum[31] != a[31]));
         end
         ACT_DIV: q_dz = (b == '0);
         ACT_AND: begin q_r1 = a & b; q_w1 = 1'b1; q_f = nz_flags(a & b, 1'b0, 1'b0); end
         ACT_OR:  begin q_r1 = a | b; q_w1 = 1'b1; q_f = nz_flags(a | b, 1'b0, 1'b0); end
         ACT_XOR: begin q_r1 = a ^ b; q_w1 = 1'b1; q_f = nz_flags(a ^ b, 1'b0, 1'b0); end
         ACT_SWAP: begin
            q_r1 = b; q_r2 = a; q_w1 = 1'b1; q_w2 = 1'b1;
            q_f = nz_flags(a, 1'b0, 1'b0);
         end
         ACT_SHL, ACT_SHR, ACT_SAR: begin
            q_r1 = sh_r; q_w1 = 1'b1; q_f = nz_flags(sh_r, sh_c, sh_v);
         end
         ACT_LDL:  begin q_r1 = {a[31:16], b[15:0] & HALF_MASK}; q_w1 = 1'b1; end
         ACT_LDH:  begin q_r1 = {b[15:0] & HALF_MASK, a[15:0]}; q_w1 = 1'b1; end
         ACT_NOT:  begin q_r1 = ~a; q_w1 = 1'b1; q_f = nz_flags(~a, 1'b0, 1'b0); end
         ACT_JMP:  q_jt = 1'b1;
         ACT_JP:   q_jt = !flags_ff[FLAG_N] && !flags_ff[FLAG_Z];
         ACT_JN:   q_jt = flags_ff[FLAG_N] && !flags_ff[FLAG_Z];
         ACT_JZ:   q_jt = flags_ff[FLAG_Z];
         ACT_JC:   q_jt = flags_ff[FLAG_C];
         ACT_JV:   q_jt = flags_ff[FLAG_V];
         ACT_JNP:  q_jt = flags_ff[FLAG_N] || flags_ff[FLAG_Z];
         ACT_JNN:  q_jt = !flags_ff[FLAG_N];
         ACT_JNZ:  q_jt = !flags_ff[FLAG_Z];
         ACT_STOP: q_stop = 1'b1;
         default: ;   // mul and unused codes: nothing here
      endcase
      if (q_jt) q_tgt = base_ff + a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READY;
         flags_ff     <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) base_ff <= csr_write_data;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;

         if (accept && use_md) begin
            state_ff   <= ST_BUSY;
            div_ff     <= (req_action == ACT_DIV);
            div_ovf_ff <= (a == 32'h8000_0000) && (b == 32'hFFFF_FFFF);
         end else if (accept) begin
            rsp_valid_ff <= 1'b1;
            flags_ff <= q_f;
            fo_ff  <= q_f;
            r1_ff  <= q_r1;  w1_ff <= q_w1;
            r2_ff  <= q_r2;  w2_ff <= q_w2;
            rem_ff <= '0;    wr_ff <= 1'b0;
            jt_ff  <= q_jt;  tgt_ff <= q_tgt;
            stop_ff <= q_stop; dz_ff <= q_dz;
         end

         if (md_sts.done) begin
            state_ff     <= ST_READY;
            rsp_valid_ff <= 1'b1;
            r1_ff  <= md_sts.low; w1_ff <= 1'b1;
            r2_ff  <= '0;  w2_ff <= 1'b0;
            rem_ff <= div_ff ? md_sts.high : 32'd0;
            wr_ff  <= div_ff;
            jt_ff  <= 1'b0; tgt_ff <= '0;
            stop_ff <= 1'b0; dz_ff <= 1'b0;
            if (div_ff) begin
               flags_ff <= nz_flags(md_sts.low, 1'b0, div_ovf_ff);
               fo_ff    <= nz_flags(md_sts.low, 1'b0, div_ovf_ff);
            end else begin
               flags_ff <= nz_flags(md_sts.low, md_sts.carry, md_sts.ovf);
               fo_ff    <= nz_flags(md_sts.low, md_sts.carry, md_sts.ovf);
            end
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_first    = r1_ff;
   assign rsp_write_first     = w1_ff;
   assign rsp_result_second   = r2_ff;
   assign rsp_write_second    = w2_ff;
   assign rsp_remainder       = rem_ff;
   assign rsp_write_remainder = wr_ff;
   assign rsp_flags_out       = fo_ff;
   assign rsp_jump_taken      = jt_ff;
   assign rsp_jump_target     = tgt_ff;
   assign rsp_stop_request    = stop_ff;
   assign rsp_divide_by_zero  = dz_ff;

endmodule

### rtl/anzcv_muldiv.sv
// ---------------------------------------------------------------------------
// anzcv_muldiv : iterative multiply / divide unit
// One shared 34-bit adder, one bit per cycle: shift-add multiply on the
// raw operands or restoring divide on magnitudes, then a fix-up state.
// ---------------------------------------------------------------------------
module anzcv_muldiv (
   input  logic                   clock,
   input  logic                   reset,
   input  anzcv_pkg::md_ctl_type  ctl,
   input  logic [31:0]            operand_a,
   input  logic [31:0]            operand_b,
   output anzcv_pkg::md_sts_type  sts
);
   import anzcv_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIX} state_type;

   state_type   state_ff;
   logic [4:0]  cnt_ff;
   logic        div_ff, an_ff, bn_ff;
   logic [31:0] hi_ff, lo_ff, b_ff, a_ff;
   logic        done_ff, carry_ff, ovf_ff;
   logic [31:0] low_ff, high_ff;

   logic [32:0] add_x, add_y;
   logic [33:0] add_s;
   logic [31:0] hi_signed;

   // shared adder: add for multiply, trial subtract for divide
   always_comb begin
      add_x = div_ff ? {hi_ff, lo_ff[31]} : {1'b0, hi_ff};
      add_y = (div_ff || lo_ff[0]) ? {1'b0, b_ff} : '0;
      add_s = {1'b0, add_x} + ({1'b0, add_y} ^ {34{div_ff}}) + {33'd0, div_ff};
      // signed high word from the unsigned product
      hi_signed = hi_ff - (an_ff ? b_ff : 32'd0) - (bn_ff ? a_ff : 32'd0);
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (ctl.start) begin
                  div_ff   <= ctl.is_div;
                  an_ff    <= operand_a[31];
                  bn_ff    <= operand_b[31];
                  a_ff     <= operand_a;
                  hi_ff    <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_RUN;
                  if (ctl.is_div) begin
                     lo_ff <= operand_a[31] ? 32'd0 - operand_a : operand_a;
                     b_ff  <= operand_b[31] ? 32'd0 - operand_b : operand_b;
                  end else begin
                     lo_ff <= operand_a;
                     b_ff  <= operand_b;
                  end
               end
            end
            ST_RUN: begin
               if (div_ff) begin
                  hi_ff <= add_s[33] ? add_x[31:0] : add_s[31:0];
                  lo_ff <= {lo_ff[30:0], ~add_s[33]};
               end else begin
                  hi_ff <= add_s[32:1];
                  lo_ff <= {add_s[0], lo_ff[31:1]};
               end
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) state_ff <= ST_FIX;
            end
            ST_FIX: begin
               if (div_ff) begin
                  low_ff  <= (an_ff ^ bn_ff) ? 32'd0 - lo_ff : lo_ff;
                  high_ff <= an_ff ? 32'd0 - hi_ff : hi_ff;
               end else begin
                  low_ff  <= lo_ff;
                  high_ff <= hi_ff;
               end
               carry_ff <= (hi_ff != '0);
               ovf_ff   <= (hi_signed != {32{lo_ff[31]}});
               done_ff  <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign sts.done  = done_ff;
   assign sts.low   = low_ff;
   assign sts.high  = high_ff;
   assign sts.carry = carry_ff;
   assign sts.ovf   = ovf_ff;

endmodule
